FILE: design/dhks_pkg.sv
// shared types and constants for the double-hashed key set
// no dependencies
package dhks_pkg;
    localparam int unsigned CapacityDef = 1024;
    localparam int unsigned SlotsDef = 2048;
    localparam int unsigned KeyW = 64;
    localparam int unsigned HashW = 32;
    localparam int unsigned IndexW = 10;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request, start probe at first slot
        logic probe_rd;   // read slot table at probe pointer
        logic entry_rd;   // read key/hash stores at slot entry
        logic advance;    // step probe pointer
        logic ins_wr;     // append captured key
        logic mv_rd;      // read last entry
        logic mv_wr;      // write last entry into freed index
        logic cnt_dec;    // entry count minus one
        logic clr_wr;     // clear slot table at clear pointer
        logic clr_start;  // reset clear pointer
        logic rb_start;   // start rebuild with e = count
        logic rb_rd;      // read hash of rebuild entry
        logic rb_load;    // start probe from rebuild hash
        logic rb_place;   // write rebuild entry into probe slot
        logic res_set;    // latch result
        logic res_hit;    // result: found
        logic res_full;   // result: dropped
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic slot_used;
        logic match;
        logic full;
        logic probe_done;
        logic clr_done;
        logic rb_done;
        logic no_last;
    } t_sts;
endpackage

FILE: design/dhks_ram.sv
// generic single-port ram with registered read
// no dependencies
module dhks_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

FILE: design/dhks_datapath.sv
// datapath: stores, slot table, probe pointer and result registers
// depends on dhks_pkg and dhks_ram
module dhks_datapath #(
    parameter int unsigned CAPACITY = dhks_pkg::CapacityDef,
    parameter int unsigned SLOTS = dhks_pkg::SlotsDef
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dhks_pkg::t_cmd            i_cmd,
    output dhks_pkg::t_sts            o_sts,
    input  logic [dhks_pkg::KeyW-1:0] i_key,
    input  logic [dhks_pkg::HashW-1:0] i_hash,
    output logic [dhks_pkg::IndexW-1:0] o_index,
    output logic                      o_present,
    output logic                      o_full
);
    import dhks_pkg::*;
    localparam int unsigned SW = $clog2(SLOTS);
    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = AW + 1;

    logic [KeyW-1:0] r_key;
    logic [HashW-1:0] r_hash;
    logic [SW-1:0] r_ptr, r_step, r_clr, r_slot_addr;
    logic [CW-1:0] r_count, r_rb;
    logic [AW-1:0] r_idx, r_ent;
    logic r_used_rd;
    logic [IndexW-1:0] r_index;
    logic r_present, r_full;

    // slot table entry: used flag above entry number
    logic st_we;
    logic [SW-1:0] st_addr;
    logic [CW:0] st_wdata, st_rdata;
    logic ks_we;
    logic [AW-1:0] ks_addr;
    logic [KeyW-1:0] ks_wdata, ks_rdata;
    logic [HashW-1:0] hs_wdata, hs_rdata;
    logic [HashW-1:0] hsel;
    logic [AW-1:0] last;
    logic [CW-1:0] slot_e;

    assign last = AW'(r_count - CW'(1));
    assign hsel = i_cmd.rb_load ? hs_rdata : i_hash;
    assign slot_e = st_rdata[CW-1:0];

    always_comb begin
        st_we = i_cmd.clr_wr | i_cmd.ins_wr | i_cmd.rb_place;
        st_addr = i_cmd.clr_wr ? r_clr : r_ptr;
        st_wdata = '0;
        if (i_cmd.ins_wr) begin
            st_wdata = {1'b1, r_count};
        end else if (i_cmd.rb_place) begin
            st_wdata = {1'b1, r_rb};
        end
        ks_we = i_cmd.ins_wr | i_cmd.mv_wr;
        ks_addr = r_ent;
        if (i_cmd.ins_wr) begin
            ks_addr = AW'(r_count);
        end else if (i_cmd.mv_wr) begin
            ks_addr = r_idx;
        end else if (i_cmd.mv_rd) begin
            ks_addr = last;
        end else if (i_cmd.rb_rd) begin
            // rebuild walks entries from count-1 down to 0
            ks_addr = AW'(r_rb - CW'(1));
        end else if (i_cmd.entry_rd) begin
            ks_addr = AW'(slot_e);
        end
        ks_wdata = i_cmd.ins_wr ? r_key : ks_rdata;
        hs_wdata = i_cmd.ins_wr ? r_hash : hs_rdata;
    end

    dhks_ram #(.WIDTH(CW + 1), .DEPTH(SLOTS)) u_slot (
        .i_clk, .i_we(st_we), .i_addr(st_addr), .i_wdata(st_wdata), .o_rdata(st_rdata));
    dhks_ram #(.WIDTH(KeyW), .DEPTH(CAPACITY)) u_key (
        .i_clk, .i_we(ks_we), .i_addr(ks_addr), .i_wdata(ks_wdata), .o_rdata(ks_rdata));
    dhks_ram #(.WIDTH(HashW), .DEPTH(CAPACITY)) u_hash (
        .i_clk, .i_we(ks_we), .i_addr(ks_addr), .i_wdata(hs_wdata), .o_rdata(hs_rdata));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_clr <= '0;
            r_present <= 1'b0;
            r_full <= 1'b0;
            r_index <= '0;
        end else begin
            if (i_cmd.load) begin
                r_key <= i_key;
                r_hash <= i_hash;
            end
            if (i_cmd.load || i_cmd.rb_load) begin
                r_ptr <= SW'(hsel ^ (hsel >> 2));
                r_step <= SW'((hsel ^ (hsel >> 16)) | HashW'(1));
            end else if (i_cmd.advance) begin
                r_ptr <= r_ptr + r_step;
            end
            if (i_cmd.probe_rd) begin
                r_slot_addr <= r_ptr;
            end
            if (i_cmd.entry_rd) begin
                r_used_rd <= st_rdata[CW];
                r_ent <= AW'(slot_e);
                r_idx <= AW'(slot_e);
            end
            if (i_cmd.ins_wr) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.clr_start) begin
                r_clr <= '0;
            end else if (i_cmd.clr_wr) begin
                r_clr <= r_clr + SW'(1);
            end
            if (i_cmd.rb_start) begin
                r_rb <= r_count;
            end else if (i_cmd.rb_rd) begin
                r_rb <= r_rb - CW'(1);
            end
            if (i_cmd.res_set) begin
                r_present <= i_cmd.res_hit;
                r_full <= i_cmd.res_full;
                if (i_cmd.res_hit) begin
                    r_index <= IndexW'(r_idx);
                end else if (i_cmd.ins_wr) begin
                    r_index <= IndexW'(r_count);
                end else begin
                    r_index <= '0;
                end
            end
        end
    end

    // entry read is valid in the cycle after entry_rd when slot was used
    logic ent_ok;
    assign ent_ok = r_used_rd && (CW'(r_ent) < r_count);

    always_comb begin
        o_sts.slot_used = st_rdata[CW];
        o_sts.match = ent_ok && hs_rdata == r_hash && ks_rdata == r_key;
        o_sts.full = r_count == CW'(CAPACITY);
        o_sts.probe_done = 1'b0;
        o_sts.clr_done = r_clr == SW'(SLOTS - 1);
        o_sts.rb_done = r_rb == '0;
        o_sts.no_last = 1'b0;
    end

    assign o_index = r_index;
    assign o_present = r_present;
    assign o_full = r_full;
    logic unused;
    assign unused = ^r_slot_addr;
endmodule

FILE: design/dhks_ctrl.sv
// controller state machine for the key set
// depends on dhks_pkg
module dhks_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dhks_pkg::t_action i_action,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dhks_pkg::t_cmd    o_cmd,
    input  dhks_pkg::t_sts    i_sts
);
    import dhks_pkg::*;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_PRD   = 12'b000000000100,
        S_ERD   = 12'b000000001000,
        S_CMP   = 12'b000000010000,
        S_MVRD  = 12'b000000100000,
        S_MVWR  = 12'b000001000000,
        S_RCLR  = 12'b000010000000,
        S_RBRD  = 12'b000100000000,
        S_RBLD  = 12'b001000000000,
        S_RBPR  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    t_action r_act;
    logic r_out_valid, n_out_valid;
    logic r_rb_wait, n_rb_wait;

    assign o_in_ready = r_state == S_IDLE && !r_out_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid;
        n_rb_wait = r_rb_wait;
        o_cmd = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    if (i_action == ACT_NONE) begin
                        o_cmd.res_set = 1'b1;
                        n_out_valid = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state = S_PRD;
                    end
                end
            end
            S_PRD: n_state = S_ERD;  // slot read in flight
            S_ERD: begin
                if (!i_sts.slot_used) begin
                    o_cmd.res_set = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                    if (r_act == ACT_INSERT) begin
                        if (i_sts.full) begin
                            o_cmd.res_full = 1'b1;
                        end else begin
                            o_cmd.ins_wr = 1'b1;
                        end
                    end
                end else begin
                    o_cmd.entry_rd = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.match) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_hit = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = (r_act == ACT_REMOVE) ? S_MVRD : S_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = S_PRD;
                end
            end
            S_MVRD: begin
                o_cmd.mv_rd = 1'b1;
                n_state = S_MVWR;
            end
            S_MVWR: begin
                o_cmd.mv_wr = 1'b1;
                o_cmd.cnt_dec = 1'b1;
                o_cmd.clr_start = 1'b1;
                n_state = S_RCLR;
            end
            S_RCLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) begin
                    o_cmd.rb_start = 1'b1;
                    n_state = S_RBRD;
                end
            end
            S_RBRD: begin
                if (i_sts.rb_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.rb_rd = 1'b1;
                    n_state = S_RBLD;
                end
            end
            S_RBLD: begin
                o_cmd.rb_load = 1'b1;
                n_rb_wait = 1'b1;
                n_state = S_RBPR;
            end
            S_RBPR: begin
                // with r_rb_wait set the slot read is in flight, with it clear the data is seen
                if (r_rb_wait) begin
                    n_rb_wait = 1'b0;
                end else if (i_sts.slot_used) begin
                    o_cmd.advance = 1'b1;
                    n_rb_wait = 1'b1;
                end else begin
                    o_cmd.rb_place = 1'b1;
                    n_state = S_RBRD;
                end
            end
            S_OUT: n_state = r_out_valid ? S_OUT : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_rb_wait <= 1'b0;
            r_act <= ACT_NONE;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            r_rb_wait <= n_rb_wait;
            if (o_cmd.load) begin
                r_act <= i_action;
            end
        end
    end
endmodule

FILE: design/double_hash_key_set_core.sv
// Keyed set with dense indices and a double-hashed slot table. One result per
// request. Insert and lookup probe the slot table with a slot read then an entry
// read, each through a registered ram, the entry read being skipped when the probe
// lands on a free slot; remove of a present key also moves the last entry,
// clears the slot table and re-inserts every remaining entry. After reset a
// clearing pass runs before the first request is accepted.
// depends on dhks_pkg, dhks_ctrl, dhks_datapath, dhks_ram
module double_hash_key_set_core #(
    parameter int unsigned CAPACITY = dhks_pkg::CapacityDef,
    parameter int unsigned SLOTS = dhks_pkg::SlotsDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // action[1:0], key[65:2], raw_hash[97:66]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata   // index[9:0], present[10], full_res[11]
);
    import dhks_pkg::*;
    t_cmd cmd;
    t_sts sts;
    logic [IndexW-1:0] index;
    logic present, full;

    dhks_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_action(t_action'(s_axis_tdata[1:0])),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd(cmd), .i_sts(sts));

    dhks_datapath #(.CAPACITY(CAPACITY), .SLOTS(SLOTS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_key(s_axis_tdata[65:2]), .i_hash(s_axis_tdata[97:66]),
        .o_index(index), .o_present(present), .o_full(full));

    assign m_axis_tdata = {4'b0, full, present, index};

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("accept while busy");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(present && full)) else $error("present and full");
    a_full_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && full |-> index == '0) else $error("index on drop");
endmodule

FILE: tb/sv/tb_double_hash_key_set_core.sv
// self-checking testbench for double_hash_key_set_core: a predictor of the key set
// checks every result; uses dhks_pkg and the core
module tb_double_hash_key_set_core;
    import dhks_pkg::*;

    localparam int unsigned Cap = CapacityDef;
    localparam int unsigned Slots = SlotsDef;
    localparam int unsigned SlotMask = Slots - 1;
    localparam int unsigned IdleLimit = 400000;

    typedef enum int {PROBE_FREE, PROBE_HIT, PROBE_NONE} t_probe;

    typedef struct {
        t_action     act;
        logic [63:0] key;
        logic [31:0] hash;
        bit          drain;  // hold the sender until all results are back
    } t_request;

    // packed from the top bit down: full_res, present, index
    typedef struct packed {
        logic       full_res;
        logic       present;
        logic [9:0] index;
    } t_answer;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;  // action[1:0], key[65:2], raw_hash[97:66]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [15:0]  m_axis_tdata;       // index[9:0], present[10], full_res[11]

    double_hash_key_set_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // set state mirrored by the predictor
    logic [63:0] set_keys [Cap];
    logic [31:0] set_hashes [Cap];
    int unsigned slot_entry [Slots];
    bit          slot_busy [Slots];
    int unsigned n_members;

    t_request    pending [$];
    t_answer     answers_due [$];
    int          n_errors = 0;
    int unsigned idle_cycles = 0;

    function automatic int unsigned first_slot(logic [31:0] h);
        return (h ^ (h >> 2)) & SlotMask;
    endfunction

    function automatic int unsigned probe_stride(logic [31:0] h);
        return ((h ^ (h >> 16)) | 1) & SlotMask;
    endfunction

    function automatic t_probe find_member(logic [63:0] key, logic [31:0] h,
                                           output int unsigned slot);
        int unsigned s;
        int unsigned e;
        s = first_slot(h);
        slot = 0;
        for (int unsigned n = 0; n < Slots; n++) begin
            if (!slot_busy[s]) begin
                slot = s;
                return PROBE_FREE;
            end
            e = slot_entry[s];
            if (e < n_members && e < Cap && set_hashes[e] == h && set_keys[e] == key) begin
                slot = s;
                return PROBE_HIT;
            end
            s = (s + probe_stride(h)) & SlotMask;
        end
        return PROBE_NONE;
    endfunction

    function automatic void rebuild_table();
        int unsigned s;
        for (int unsigned i = 0; i < Slots; i++) slot_busy[i] = 1'b0;
        for (int e = int'(n_members) - 1; e >= 0; e--) begin
            s = first_slot(set_hashes[e]);
            for (int unsigned n = 0; n < Slots && slot_busy[s]; n++)
                s = (s + probe_stride(set_hashes[e])) & SlotMask;
            if (!slot_busy[s]) begin
                slot_busy[s] = 1'b1;
                slot_entry[s] = e;
            end
        end
    endfunction

    function automatic t_answer apply_request(t_request r);
        t_answer     a;
        t_probe      found;
        int unsigned slot;
        int unsigned idx;
        int unsigned last;
        a = '0;
        if (r.act == ACT_NONE) return a;
        found = find_member(r.key, r.hash, slot);
        idx = 0;
        if (found == PROBE_HIT) begin
            a.present = 1'b1;
            idx = slot_entry[slot];
        end
        if (r.act == ACT_INSERT && found != PROBE_HIT) begin
            if (found == PROBE_NONE || n_members >= Cap) begin
                a.full_res = 1'b1;
            end else begin
                idx = n_members;
                set_keys[idx] = r.key;
                set_hashes[idx] = r.hash;
                slot_entry[slot] = idx;
                slot_busy[slot] = 1'b1;
                n_members++;
            end
        end else if (r.act == ACT_REMOVE && found == PROBE_HIT) begin
            last = n_members - 1;
            set_keys[idx] = set_keys[last];
            set_hashes[idx] = set_hashes[last];
            n_members = last;
            rebuild_table();
        end
        a.index = idx[9:0];
        return a;
    endfunction

    task automatic queue_request(t_action act, logic [63:0] key, logic [31:0] hash);
        t_request r;
        r.act = act;
        r.key = key;
        r.hash = hash;
        r.drain = 1'b0;
        pending.push_back(r);
    endtask

    task automatic queue_drain();
        t_request r;
        r = '{ACT_NONE, '0, '0, 1'b1};
        pending.push_back(r);
    endtask

    // sender: bursts of requests separated by random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    always @(posedge i_clk) begin
        t_request r;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // hold the offered request
        end else begin
            if (s_axis_tvalid) begin
                r = pending.pop_front();
                answers_due.push_back(apply_request(r));
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end else begin
                    burst_left--;
                end
            end
            if (pending.size() != 0 && pending[0].drain && answers_due.size() == 0)
                void'(pending.pop_front());
            if (pending.size() == 0 || pending[0].drain) begin
                s_axis_tvalid <= 1'b0;
            end else if (gap_left != 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {6'd0, pending[0].hash, pending[0].key, pending[0].act};
            end
        end
    end

    // receiver stalls: random stretches, none while bit 12 of the cycle counter is clear
    int unsigned stall_left = 0;
    int unsigned cycle_no = 0;
    always @(posedge i_clk) begin
        cycle_no++;
        if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (cycle_no[12] && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        t_answer got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[11:0];
            if (answers_due.size() == 0) begin
                $error("result with nothing outstanding: %h", m_axis_tdata);
                n_errors++;
            end else begin
                want = answers_due.pop_front();
                if (got.index !== want.index) begin
                    $error("index: expected %0d, got %0d", want.index, got.index);
                    n_errors++;
                end
                if (got.present !== want.present) begin
                    $error("present: expected %0d, got %0d", want.present, got.present);
                    n_errors++;
                end
                if (got.full_res !== want.full_res) begin
                    $error("full_res: expected %0d, got %0d", want.full_res, got.full_res);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    logic [63:0] pool_keys [48];
    logic [31:0] pool_hashes [48];

    initial begin
        int unsigned p;
        logic [31:0] h;
        t_action act;
        n_members = 0;
        for (int unsigned i = 0; i < Slots; i++) slot_busy[i] = 1'b0;

        // directed: extremes, every action, hits, misses, moves on remove
        queue_request(ACT_INSERT, 64'd0, 32'd0);
        queue_request(ACT_INSERT, '1, '1);
        queue_request(ACT_INSERT, 64'h5555_AAAA_5555_AAAA, 32'hAAAA_5555);
        queue_request(ACT_INSERT, '1, '1);
        queue_request(ACT_LOOKUP, 64'd0, 32'd0);
        queue_request(ACT_LOOKUP, '1, '1);
        queue_request(ACT_LOOKUP, '1, 32'd0);  // same key, other hash: absent
        queue_request(ACT_INSERT, '1, 32'd0);
        queue_request(ACT_REMOVE, 64'd7, 32'd7);
        queue_request(ACT_NONE, '1, '1);
        queue_request(ACT_REMOVE, 64'd0, 32'd0);  // last entry moves to index 0
        queue_request(ACT_LOOKUP, '1, 32'd0);
        queue_request(ACT_LOOKUP, 64'd0, 32'd0);
        queue_request(ACT_REMOVE, '1, 32'd0);
        queue_request(ACT_REMOVE, '1, '1);
        queue_request(ACT_REMOVE, 64'h5555_AAAA_5555_AAAA, 32'hAAAA_5555);
        queue_request(ACT_LOOKUP, 64'h5555_AAAA_5555_AAAA, 32'hAAAA_5555);
        queue_request(ACT_INSERT, 64'h8000_0000_0000_0001, 32'h8000_0001);
        queue_drain();

        // crowded hashes so probe chains get long
        for (int i = 0; i < 48; i++) begin
            pool_keys[i] = {$urandom, $urandom};
            pool_hashes[i] = {19'($urandom_range(0, 32'h7FFFF)), 13'd0}
                             | 32'($urandom_range(0, 3) * 13'h411);
        end
        for (int i = 0; i < 900; i++) begin
            p = $urandom_range(0, 47);
            h = ($urandom_range(0, 15) == 0) ? $urandom : pool_hashes[p];
            case ($urandom_range(0, 19))
                0: act = ACT_NONE;
                1, 2, 3, 4: act = ACT_REMOVE;
                5, 6, 7, 8, 9, 10: act = ACT_LOOKUP;
                default: act = ACT_INSERT;
            endcase
            if ($urandom_range(0, 9) == 0)
                queue_request(act, {$urandom, $urandom}, $urandom);
            else
                queue_request(act, pool_keys[p], h);
            if (i == 450) queue_drain();
        end
        queue_drain();

        // a few closing misses, a remove and a re-insert
        queue_request(ACT_INSERT, 64'h1234_5678_9ABC_DEF0, '1);
        queue_request(ACT_INSERT, '1, 32'hFFFF_0000);
        for (int i = 0; i < 6; i++)
            queue_request(ACT_LOOKUP, {$urandom, $urandom}, $urandom);
        queue_request(ACT_REMOVE, 64'h1234_5678_9ABC_DEF0, '1);
        queue_request(ACT_INSERT, 64'h1234_5678_9ABC_DEF0, '1);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (pending.size() != 0 || s_axis_tvalid);
        do @(posedge i_clk); while (answers_due.size() != 0);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
